### hw/rtl/fwdd_pkg.sv
// ----------------------------------------------------------------------------
// fwdd_pkg - word-delta decoder shared types and constants
// Command format between front and back, opcode classes, write kinds,
// register indexes and field widths.
// ----------------------------------------------------------------------------
package fwdd_pkg;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned OUT_ADDR_W = 20;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned LINES_W    = 16;
  localparam int unsigned PKTS_W     = 14;
  localparam int unsigned LIT_W      = 7;
  localparam int unsigned SKIP_W     = 15;
  localparam int unsigned PROD_W     = SKIP_W + CFG_DATA_W;

  localparam int unsigned CMD_FIFO_DEPTH = 2;

  localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RST = 13'd320;
  localparam logic [CFG_DATA_W-1:0] LINE_PITCH_RST = 13'd320;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH = 1'd1;

  // opcode classes, top two bits of an opcode word
  localparam logic [1:0] OPC_PACKETS = 2'b00;
  localparam logic [1:0] OPC_ERROR   = 2'b01;
  localparam logic [1:0] OPC_LASTPIX = 2'b10;
  localparam logic [1:0] OPC_SKIP    = 2'b11;

  // write kinds
  localparam logic [KIND_W-1:0] KIND_PAIR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_BYTE,
    CMD_SKIP,
    CMD_ERROR,
    CMD_PACKETS,
    CMD_HEADER,
    CMD_LITERAL,
    CMD_REPEAT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  count;     // repeat pair count
    logic              end_line;  // advance line start by pitch
    logic              done;      // last line of the chunk finished
    logic              emit;      // produces a result beat
  } cmd_t;

endpackage

### hw/rtl/fwdd_in_if.sv
// ----------------------------------------------------------------------------
// fwdd_in_if - chunk word channel
// Valid/ready channel carrying one chunk word and its start flag.
// ----------------------------------------------------------------------------
interface fwdd_in_if;
  logic                            valid;
  logic                            ready;
  logic [fwdd_pkg::WORD_W-1:0]     data_word;
  logic                            chunk_start;

  modport source (output valid, output data_word, output chunk_start, input ready);
  modport sink   (input valid, input data_word, input chunk_start, output ready);
endinterface

### hw/rtl/fwdd_out_if.sv
// ----------------------------------------------------------------------------
// fwdd_out_if - frame-buffer write command channel
// Valid/ready channel carrying one write command per beat.
// ----------------------------------------------------------------------------
interface fwdd_out_if;
  logic                              valid;
  logic                              ready;
  logic [fwdd_pkg::KIND_W-1:0]       write_kind;
  logic [fwdd_pkg::OUT_ADDR_W-1:0]   write_address;
  logic [fwdd_pkg::PIX_W-1:0]        pixel_low;
  logic [fwdd_pkg::PIX_W-1:0]        pixel_high;
  logic [fwdd_pkg::CNT_W-1:0]        pair_count;
  logic                              chunk_done;
  logic                              format_error;

  modport source (output valid, output write_kind, output write_address,
                  output pixel_low, output pixel_high, output pair_count,
                  output chunk_done, output format_error, input ready);
  modport sink   (input valid, input write_kind, input write_address,
                  input pixel_low, input pixel_high, input pair_count,
                  input chunk_done, input format_error, output ready);
endinterface

### hw/rtl/fwdd_cfg_if.sv
// ----------------------------------------------------------------------------
// fwdd_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fwdd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fwdd_pkg::CFG_IDX_W-1:0]    index;
  logic [fwdd_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

### hw/rtl/flc_word_delta_decoder_top.sv
// ----------------------------------------------------------------------------
// flc_word_delta_decoder_top - word-delta animation chunk decoder
// Turns a stream of 16-bit delta chunk words into frame-buffer write commands.
// ----------------------------------------------------------------------------
// Path: with the command queue empty, an accepted word is written into the queue,
//   then the back end pops it and registers the result beat on the output channel.
// Throughput: one word per cycle; the front stalls only when the two-entry
//   command queue is full, which happens while the output beat is held.
// Reset: parse returns to idle, counters and addresses clear, queue empties,
//   line_width and line_pitch return to 320.
module flc_word_delta_decoder_top #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fwdd_in_if.sink     in_chan,
  fwdd_out_if.source  out_chan,
  fwdd_cfg_if.sink    cfg_chan
);
  import fwdd_pkg::*;

  cmd_t cmd_push_data;
  cmd_t cmd_pop_data;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_full;
  logic cmd_empty;

  fwdd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_chan),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_push_data)
  );

  fwdd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_push_data),
    .pop_i   (cmd_pop),
    .data_o  (cmd_pop_data),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  fwdd_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_chan    (cfg_chan),
    .out_chan    (out_chan),
    .cmd_i       (cmd_pop_data),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop)
  );

endmodule

### hw/rtl/fwdd_front.sv
// ----------------------------------------------------------------------------
// fwdd_front - chunk word classifier
// Tracks the parse phase and the line, packet and literal counters, and turns
// each accepted word into a command for the back end.
// ----------------------------------------------------------------------------
module fwdd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  fwdd_in_if.sink        in_chan,
  input  logic           cmd_full_i,
  output logic           cmd_push_o,
  output fwdd_pkg::cmd_t cmd_o
);
  import fwdd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPCODE,
    PH_HEADER,
    PH_LITERAL,
    PH_REPEAT
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [LINES_W-1:0]  lines_q, lines_d;
  logic [PKTS_W-1:0]   pkts_q, pkts_d;
  logic [LIT_W-1:0]    lit_q, lit_d;
  logic [CNT_W-1:0]    rep_q, rep_d;

  logic                accept;
  logic [WORD_W-1:0]   w;
  logic [PIX_W-1:0]    hi;
  logic [LINES_W-1:0]  lines_dec;
  logic [PKTS_W-1:0]   pkts_dec;
  logic [LIT_W-1:0]    lit_dec;
  logic                pkt_end;
  logic                line_end;

  assign in_chan.ready = !cmd_full_i;
  assign accept        = in_chan.valid && !cmd_full_i;
  assign w             = in_chan.data_word;
  assign hi            = w[15:8];
  assign lines_dec     = lines_q - 1'b1;
  assign pkts_dec      = pkts_q - 1'b1;
  assign lit_dec       = lit_q - 1'b1;

  always_comb begin
    phase_d    = phase_q;
    lines_d    = lines_q;
    pkts_d     = pkts_q;
    lit_d      = lit_q;
    rep_d      = rep_q;
    pkt_end    = 1'b0;
    line_end   = 1'b0;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = CMD_START;
    cmd_o.word = w;
    cmd_o.count = rep_q;

    if (accept) begin
      if (in_chan.chunk_start) begin
        // restart the chunk wherever the parse stood
        lines_d    = w;
        pkts_d     = '0;
        lit_d      = '0;
        rep_d      = '0;
        cmd_push_o = 1'b1;
        cmd_o.op   = CMD_START;
        cmd_o.done = (w == '0);
        cmd_o.emit = (w == '0);
        phase_d    = (w == '0) ? PH_IDLE : PH_OPCODE;
      end else begin
        case (phase_q)
          PH_OPCODE: begin
            cmd_push_o = 1'b1;
            case (w[15:14])
              OPC_LASTPIX: begin
                cmd_o.op   = CMD_BYTE;
                cmd_o.emit = 1'b1;
              end
              OPC_SKIP: begin
                cmd_o.op = CMD_SKIP;
              end
              OPC_ERROR: begin
                cmd_o.op   = CMD_ERROR;
                cmd_o.emit = 1'b1;
                phase_d    = PH_IDLE;
              end
              default: begin
                cmd_o.op = CMD_PACKETS;
                pkts_d   = w[PKTS_W-1:0];
                if (w[PKTS_W-1:0] == '0) begin
                  line_end = 1'b1;
                end else begin
                  phase_d = PH_HEADER;
                end
              end
            endcase
          end
          PH_HEADER: begin
            cmd_push_o = 1'b1;
            cmd_o.op   = CMD_HEADER;
            if (hi != '0 && !hi[7]) begin
              lit_d   = hi[LIT_W-1:0];
              phase_d = PH_LITERAL;
            end else begin
              // negative count: repeat -count pairs, zero gives none
              rep_d   = CNT_W'(~hi + 1'b1);
              phase_d = PH_REPEAT;
            end
          end
          PH_LITERAL: begin
            cmd_push_o = 1'b1;
            cmd_o.op   = CMD_LITERAL;
            cmd_o.emit = 1'b1;
            lit_d      = lit_dec;
            pkt_end    = (lit_dec == '0);
          end
          PH_REPEAT: begin
            cmd_push_o = 1'b1;
            cmd_o.op   = CMD_REPEAT;
            cmd_o.emit = 1'b1;
            rep_d      = '0;
            pkt_end    = 1'b1;
          end
          default: begin
            // drop words outside a chunk
          end
        endcase

        if (pkt_end) begin
          pkts_d = pkts_dec;
          if (pkts_dec == '0) begin
            line_end = 1'b1;
          end else begin
            phase_d = PH_HEADER;
          end
        end

        if (line_end) begin
          cmd_o.end_line = 1'b1;
          lines_d        = lines_dec;
          if (lines_dec == '0) begin
            cmd_o.done = 1'b1;
            cmd_o.emit = 1'b1;
            phase_d    = PH_IDLE;
          end else begin
            phase_d = PH_OPCODE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      lines_q <= '0;
      pkts_q  <= '0;
      lit_q   <= '0;
      rep_q   <= '0;
    end else begin
      phase_q <= phase_d;
      lines_q <= lines_d;
      pkts_q  <= pkts_d;
      lit_q   <= lit_d;
      rep_q   <= rep_d;
    end
  end

endmodule

### hw/rtl/fwdd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fwdd_cmd_fifo - command queue
// Short queue between classifier and executor so each side stalls alone.
// ----------------------------------------------------------------------------
module fwdd_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fwdd_pkg::cmd_t data_i,
  input  logic           pop_i,
  output fwdd_pkg::cmd_t data_o,
  output logic           full_o,
  output logic           empty_o
);
  import fwdd_pkg::*;

  localparam int unsigned PtrW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t            mem_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(CMD_FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("command popped from empty queue");

endmodule

### hw/rtl/fwdd_back.sv
// ----------------------------------------------------------------------------
// fwdd_back - address tracker and write command builder
// Holds the configuration and the line and write addresses, executes queued
// commands and drives the registered output channel.
// ----------------------------------------------------------------------------
module fwdd_back #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  fwdd_cfg_if.sink       cfg_chan,
  fwdd_out_if.source     out_chan,
  input  fwdd_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o
);
  import fwdd_pkg::*;

  typedef logic [ADDR_BITS-1:0] addr_t;

  logic [CFG_DATA_W-1:0] width_q, pitch_q;
  addr_t                 ls_q, ls_d;
  addr_t                 wp_q, wp_d;

  logic                  out_valid_q;
  logic [KIND_W-1:0]     kind_q, kind_d;
  addr_t                 addr_q, addr_d;
  logic [PIX_W-1:0]      lo_q, lo_d;
  logic [PIX_W-1:0]      hi_q, hi_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic                  err_q, err_d;

  logic [WORD_W-1:0]     skip16;
  logic [PROD_W-1:0]     skip_prod;
  addr_t                 ls_next_line;

  assign cfg_chan.ready = 1'b1;

  // take a command unless it must emit while the output beat is still held
  assign cmd_pop_o = !cmd_empty_i && (!out_valid_q || out_chan.ready || !cmd_i.emit);

  assign skip16       = ~cmd_i.word + 1'b1;
  assign skip_prod    = PROD_W'(skip16[SKIP_W-1:0]) * PROD_W'(pitch_q);
  assign ls_next_line = ls_q + addr_t'(pitch_q);

  always_comb begin
    ls_d   = ls_q;
    wp_d   = wp_q;
    kind_d = KIND_NONE;
    addr_d = '0;
    lo_d   = '0;
    hi_d   = '0;
    cnt_d  = '0;
    done_d = cmd_i.done;
    err_d  = 1'b0;

    case (cmd_i.op)
      CMD_START: begin
        ls_d = '0;
        wp_d = '0;
      end
      CMD_BYTE: begin
        kind_d = KIND_BYTE;
        addr_d = ls_q + addr_t'(width_q) - addr_t'(1);
        lo_d   = cmd_i.word[7:0];
      end
      CMD_SKIP: begin
        ls_d = ls_q + addr_t'(skip_prod);
      end
      CMD_ERROR: begin
        err_d = 1'b1;
      end
      CMD_PACKETS: begin
        wp_d = ls_q;
        if (cmd_i.end_line) begin
          ls_d = ls_next_line;
        end
      end
      CMD_HEADER: begin
        wp_d = wp_q + addr_t'(cmd_i.word[7:0]);
      end
      CMD_LITERAL: begin
        kind_d = KIND_PAIR;
        addr_d = wp_q;
        lo_d   = cmd_i.word[7:0];
        hi_d   = cmd_i.word[15:8];
        cnt_d  = CNT_W'(1);
        wp_d   = wp_q + addr_t'(2);
        if (cmd_i.end_line) begin
          ls_d = ls_next_line;
        end
      end
      CMD_REPEAT: begin
        if (cmd_i.count != '0) begin
          kind_d = KIND_PAIR;
          addr_d = wp_q;
          lo_d   = cmd_i.word[7:0];
          hi_d   = cmd_i.word[15:8];
          cnt_d  = cmd_i.count;
        end
        wp_d = wp_q + addr_t'({cmd_i.count, 1'b0});
        if (cmd_i.end_line) begin
          ls_d = ls_next_line;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= LINE_WIDTH_RST;
      pitch_q     <= LINE_PITCH_RST;
      ls_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          REG_LINE_WIDTH: width_q <= cfg_chan.wdata;
          REG_LINE_PITCH: pitch_q <= cfg_chan.wdata;
          default: begin
          end
        endcase
      end
      if (cmd_pop_o) begin
        ls_q <= ls_d;
        wp_q <= wp_d;
      end
      if (cmd_pop_o && cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.emit) begin
      kind_q <= kind_d;
      addr_q <= addr_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
      err_q  <= err_d;
    end
  end

  assign out_chan.valid         = out_valid_q;
  assign out_chan.write_kind    = kind_q;
  assign out_chan.write_address = OUT_ADDR_W'(addr_q);
  assign out_chan.pixel_low     = lo_q;
  assign out_chan.pixel_high    = hi_q;
  assign out_chan.pair_count    = cnt_q;
  assign out_chan.chunk_done    = done_q;
  assign out_chan.format_error  = err_q;

  a_err_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && err_q |-> kind_q == KIND_NONE && !done_q)
    else $error("format error beat carries a write");

  a_none_zero_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_NONE |-> addr_q == '0 && cnt_q == '0)
    else $error("no-write beat carries address or count");

  a_held_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_chan.ready |=> out_valid_q && $stable(addr_q) && $stable(kind_q))
    else $error("output beat dropped or changed while stalled");

endmodule

### tb/sv/fwdd_write_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fwdd_write_checker - frame-buffer write prediction and compare
// Watches the word, write and register channels, decodes every accepted chunk
// word into the write command it should cause, and compares each write beat
// field by field against the oldest expected command.
// ----------------------------------------------------------------------------
module fwdd_write_checker #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [15:0]           in_word_i,
  input  logic                  in_start_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [1:0]            out_kind_i,
  input  logic [19:0]           out_addr_i,
  input  logic [7:0]            out_lo_i,
  input  logic [7:0]            out_hi_i,
  input  logic [7:0]            out_count_i,
  input  logic                  out_done_i,
  input  logic                  out_err_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic                  cfg_index_i,
  input  logic [12:0]           cfg_wdata_i,
  output int                    mismatches_o,
  output int                    outstanding_o
);
  import fwdd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPCODE,
    PH_HEADER,
    PH_LITERAL,
    PH_REPEAT
  } parse_phase_e;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [OUT_ADDR_W-1:0] addr;
    logic [PIX_W-1:0]      lo;
    logic [PIX_W-1:0]      hi;
    logic [CNT_W-1:0]      count;
    logic                  done;
    logic                  err;
  } fb_write_t;

  fb_write_t              pending_writes[$];
  int                     mismatches = 0;
  int                     pending_count = 0;

  logic [CFG_DATA_W-1:0]  line_width;
  logic [CFG_DATA_W-1:0]  line_pitch;
  parse_phase_e           parse_ph;
  logic [LINES_W-1:0]     lines_left;
  logic [ADDR_BITS-1:0]   line_base;
  logic [ADDR_BITS-1:0]   write_ptr;
  logic [PKTS_W-1:0]      packets_left;
  logic [LIT_W-1:0]       literals_left;
  logic [CNT_W-1:0]       repeat_pairs;

  assign mismatches_o  = mismatches;
  assign outstanding_o = pending_count;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: write beat mismatch on %s: got 0x%0h, expected 0x%0h",
             $time, field, got, want);
    mismatches++;
  endtask

  function automatic void queue_write(input logic [KIND_W-1:0] kind,
                                      input logic [ADDR_BITS-1:0] addr,
                                      input logic [7:0] lo, input logic [7:0] hi,
                                      input logic [7:0] count, input logic done,
                                      input logic err);
    fb_write_t w;
    w.kind  = kind;
    w.addr  = OUT_ADDR_W'(addr);
    w.lo    = lo;
    w.hi    = hi;
    w.count = count;
    w.done  = done;
    w.err   = err;
    pending_writes.push_back(w);
  endfunction

  // Returns 1 when the line just closed was the last of the chunk.
  function automatic logic finish_line();
    line_base  = line_base + ADDR_BITS'(line_pitch);
    lines_left = lines_left - 1'b1;
    if (lines_left == '0) begin
      parse_ph = PH_IDLE;
      return 1'b1;
    end
    parse_ph = PH_OPCODE;
    return 1'b0;
  endfunction

  function automatic logic finish_packet();
    packets_left = packets_left - 1'b1;
    if (packets_left == '0) return finish_line();
    parse_ph = PH_HEADER;
    return 1'b0;
  endfunction

  task automatic decode_word(input logic [15:0] w, input logic start);
    logic [7:0]           lo;
    logic [7:0]           hi;
    logic [15:0]          skip_lines;
    logic [ADDR_BITS-1:0] at;
    logic [7:0]           n;
    logic                 fin;
    lo = w[7:0];
    hi = w[15:8];
    if (start) begin
      lines_left    = w;
      line_base     = '0;
      write_ptr     = '0;
      packets_left  = '0;
      literals_left = '0;
      repeat_pairs  = '0;
      if (w == '0) begin
        parse_ph = PH_IDLE;
        queue_write(KIND_NONE, '0, 8'h0, 8'h0, 8'h0, 1'b1, 1'b0);
      end else begin
        parse_ph = PH_OPCODE;
      end
    end else begin
      case (parse_ph)
        PH_OPCODE: begin
          case (w[15:14])
            OPC_LASTPIX: begin
              at = line_base + ADDR_BITS'(line_width) - ADDR_BITS'(1);
              queue_write(KIND_BYTE, at, lo, 8'h0, 8'h0, 1'b0, 1'b0);
            end
            OPC_SKIP: begin
              // the opcode holds the negated line count
              skip_lines = 16'h0 - w;
              line_base  = line_base + ADDR_BITS'(32'(skip_lines) * 32'(line_pitch));
            end
            OPC_ERROR: begin
              parse_ph = PH_IDLE;
              queue_write(KIND_NONE, '0, 8'h0, 8'h0, 8'h0, 1'b0, 1'b1);
            end
            default: begin
              packets_left = w[13:0];
              write_ptr    = line_base;
              if (packets_left == '0) begin
                if (finish_line()) queue_write(KIND_NONE, '0, 8'h0, 8'h0, 8'h0, 1'b1, 1'b0);
              end else begin
                parse_ph = PH_HEADER;
              end
            end
          endcase
        end
        PH_HEADER: begin
          write_ptr = write_ptr + ADDR_BITS'(lo);
          if (!hi[7] && hi != 8'h0) begin
            literals_left = hi[6:0];
            parse_ph      = PH_LITERAL;
          end else begin
            // zero count gives zero pairs, 0x80 gives 128
            repeat_pairs = 8'h0 - hi;
            parse_ph     = PH_REPEAT;
          end
        end
        PH_LITERAL: begin
          at            = write_ptr;
          write_ptr     = write_ptr + ADDR_BITS'(2);
          literals_left = literals_left - 1'b1;
          fin           = 1'b0;
          if (literals_left == '0) fin = finish_packet();
          queue_write(KIND_PAIR, at, lo, hi, 8'd1, fin, 1'b0);
        end
        PH_REPEAT: begin
          n            = repeat_pairs;
          at           = write_ptr;
          write_ptr    = write_ptr + ADDR_BITS'({n, 1'b0});
          repeat_pairs = '0;
          fin          = finish_packet();
          if (n == 8'h0) queue_write(KIND_NONE, '0, 8'h0, 8'h0, 8'h0, fin, 1'b0);
          else queue_write(KIND_PAIR, at, lo, hi, n, fin, 1'b0);
        end
        default: parse_ph = PH_IDLE;
      endcase
    end
  endtask

  task automatic check_write();
    fb_write_t want;
    if (pending_writes.size() == 0) begin
      report_mismatch("unexpected beat, write_kind", 32'(out_kind_i), 32'h0);
      return;
    end
    want = pending_writes.pop_front();
    if (out_kind_i !== want.kind)   report_mismatch("write_kind", 32'(out_kind_i), 32'(want.kind));
    if (out_addr_i !== want.addr)   report_mismatch("write_address", 32'(out_addr_i),
                                                    32'(want.addr));
    if (out_lo_i !== want.lo)       report_mismatch("pixel_low", 32'(out_lo_i), 32'(want.lo));
    if (out_hi_i !== want.hi)       report_mismatch("pixel_high", 32'(out_hi_i), 32'(want.hi));
    if (out_count_i !== want.count) report_mismatch("pair_count", 32'(out_count_i),
                                                    32'(want.count));
    if (out_done_i !== want.done)   report_mismatch("chunk_done", 32'(out_done_i), 32'(want.done));
    if (out_err_i !== want.err)     report_mismatch("format_error", 32'(out_err_i), 32'(want.err));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width    = LINE_WIDTH_RST;
      line_pitch    = LINE_PITCH_RST;
      parse_ph      = PH_IDLE;
      lines_left    = '0;
      line_base     = '0;
      write_ptr     = '0;
      packets_left  = '0;
      literals_left = '0;
      repeat_pairs  = '0;
      pending_writes.delete();
      pending_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LINE_WIDTH: line_width = cfg_wdata_i;
          REG_LINE_PITCH: line_pitch = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) decode_word(in_word_i, in_start_i);
      if (out_valid_i && out_ready_i) check_write();
      pending_count = pending_writes.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - word-delta decoder testbench
// Feeds directed and random delta chunks through the decoder under several
// line width and pitch settings, with random gaps on both sides, a long
// output hold-off and mid-run drains; the write checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import fwdd_pkg::*;

  localparam int unsigned ITEM_TARGET   = 2000;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int   words_sent  = 0;
  int   hold_asks   = 0;
  int   cycles      = 0;
  bit   src_idle_on = 1'b1;
  bit   snk_idle_on = 1'b1;
  int   mismatches;
  int   outstanding;

  fwdd_in_if  words_if ();
  fwdd_out_if writes_if ();
  fwdd_cfg_if regs_if ();

  always #5 clk_i = ~clk_i;

  flc_word_delta_decoder_top #(.ADDR_BITS(20)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (words_if),
    .out_chan (writes_if),
    .cfg_chan (regs_if)
  );

  fwdd_write_checker #(.ADDR_BITS(20)) write_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (words_if.valid),
    .in_ready_i    (words_if.ready),
    .in_word_i     (words_if.data_word),
    .in_start_i    (words_if.chunk_start),
    .out_valid_i   (writes_if.valid),
    .out_ready_i   (writes_if.ready),
    .out_kind_i    (writes_if.write_kind),
    .out_addr_i    (writes_if.write_address),
    .out_lo_i      (writes_if.pixel_low),
    .out_hi_i      (writes_if.pixel_high),
    .out_count_i   (writes_if.pair_count),
    .out_done_i    (writes_if.chunk_done),
    .out_err_i     (writes_if.format_error),
    .cfg_valid_i   (regs_if.valid),
    .cfg_ready_i   (regs_if.ready),
    .cfg_index_i   (regs_if.index),
    .cfg_wdata_i   (regs_if.wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("flc_word_delta_decoder_top verification failed");
      $finish;
    end
  end

  // write sink: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int holds_done;
    holds_done = 0;
    writes_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_done) begin
        holds_done++;
        writes_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (snk_idle_on) begin
        writes_if.ready <= ($urandom_range(99) >= 33);
      end else begin
        writes_if.ready <= 1'b1;
      end
    end
  end

  // Leave valid high after the beat so back-to-back words need no toggle.
  task automatic send_word(input logic [15:0] w, input logic start);
    if (src_idle_on && $urandom_range(99) < 33) begin
      words_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    words_if.valid       <= 1'b1;
    words_if.data_word   <= w;
    words_if.chunk_start <= start;
    do @(posedge clk_i); while (!words_if.ready);
  endtask

  task automatic feed(input logic [15:0] w, input logic start);
    send_word(w, start);
    words_sent++;
  endtask

  // Drop valid, let the checker see the last beat, wait for every expected
  // write, then let the pipe empty.
  task automatic settle();
    words_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    regs_if.valid <= 1'b1;
    regs_if.index <= idx;
    regs_if.wdata <= val;
    do @(posedge clk_i); while (!regs_if.ready);
  endtask

  task automatic send_packet();
    logic [7:0] cnt;
    int         r;
    r = $urandom_range(99);
    if (r < 45)      cnt = 8'($urandom_range(6, 1));
    else if (r < 47) cnt = 8'd127;
    else if (r < 52) cnt = 8'd0;
    else if (r < 55) cnt = 8'd128;
    else             cnt = 8'($urandom_range(255, 129));
    feed({cnt, 8'($urandom)}, 1'b0);
    if (!cnt[7] && cnt != 8'd0) repeat (cnt) feed(16'($urandom), 1'b0);
    else feed(16'($urandom), 1'b0);
  endtask

  task automatic send_chunk();
    int lines;
    int span;
    int pk;
    int r;
    if ($urandom_range(99) < 4) begin
      send_word(16'($urandom), 1'($urandom_range(1)));
      return;
    end
    lines = ($urandom_range(99) < 5) ? $urandom_range(65535) : $urandom_range(4, 1);
    span  = (lines > 4) ? 4 : lines;
    feed(16'(lines), 1'b1);
    for (int ln = 0; ln < span; ln++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        feed({OPC_ERROR, 14'($urandom)}, 1'b0);
        return;
      end
      // abandon: the next chunk start cuts in mid-line
      if (r < 6) return;
      while ($urandom_range(99) < 25)
        feed({($urandom_range(1) ? OPC_LASTPIX : OPC_SKIP), 14'($urandom)}, 1'b0);
      pk = ($urandom_range(99) < 3) ? $urandom_range(16383) : $urandom_range(3);
      feed({OPC_PACKETS, 14'(pk)}, 1'b0);
      for (int k = 0; k < ((pk > 4) ? 4 : pk); k++) send_packet();
      if (pk > 4) return;
    end
  endtask

  task automatic run_directed();
    feed(16'd0, 1'b1);                       // empty chunk finishes at once
    feed(16'd3, 1'b1);
    feed({OPC_LASTPIX, 14'h00AB}, 1'b0);
    feed({OPC_SKIP, 14'h3FFE}, 1'b0);        // skip two lines
    feed({OPC_PACKETS, 14'd2}, 1'b0);
    feed({8'd2, 8'd5}, 1'b0);
    feed(16'h1234, 1'b0);
    feed(16'hFFFF, 1'b0);
    feed({8'hFE, 8'hFF}, 1'b0);
    feed(16'hA55A, 1'b0);
    feed({OPC_PACKETS, 14'd0}, 1'b0);        // empty line
    feed({OPC_PACKETS, 14'd3}, 1'b0);
    feed({8'h00, 8'h00}, 1'b0);              // zero repeat count
    feed(16'h0000, 1'b0);
    feed({8'h80, 8'h00}, 1'b0);              // 128 pairs
    feed(16'h00FF, 1'b0);
    feed({8'h01, 8'h01}, 1'b0);
    feed(16'hFFFF, 1'b0);                    // closes the chunk
    feed(16'h1234, 1'b0);                    // ignored while idle
    feed(16'd5, 1'b1);
    feed({OPC_ERROR, 14'h3FFF}, 1'b0);
    feed(16'hBEEF, 1'b0);
    feed(16'd2, 1'b1);
    feed({OPC_PACKETS, 14'd1}, 1'b0);
    feed(16'hFFFF, 1'b1);                    // restart mid-line
    feed({OPC_SKIP, 14'h0000}, 1'b0);
    feed({OPC_LASTPIX, 14'h3FFF}, 1'b0);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] widths [PHASES];
    logic [CFG_DATA_W-1:0] pitches [PHASES];
    widths  = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd320, 13'd4095};
    pitches = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd320, 13'd4096};
    widths[4]  = 13'($urandom_range(8191));
    pitches[4] = 13'($urandom_range(8191));

    words_if.valid       <= 1'b0;
    words_if.data_word   <= '0;
    words_if.chunk_start <= 1'b0;
    regs_if.valid        <= 1'b0;
    regs_if.index        <= REG_LINE_WIDTH;
    regs_if.wdata        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if ($urandom_range(1)) begin
        write_reg(REG_LINE_WIDTH, widths[p]);
        write_reg(REG_LINE_PITCH, pitches[p]);
      end else begin
        write_reg(REG_LINE_PITCH, pitches[p]);
        write_reg(REG_LINE_WIDTH, widths[p]);
      end
      regs_if.valid <= 1'b0;
      src_idle_on = (p != 1);
      snk_idle_on = (p != 1);
      if (p == 2) begin
        // hold the sink while a dense line keeps arriving, so the input stalls
        hold_asks++;
        feed(16'd1, 1'b1);
        feed({OPC_PACKETS, 14'd1}, 1'b0);
        feed({8'd16, 8'($urandom)}, 1'b0);
        repeat (16) feed(16'($urandom), 1'b0);
      end
      while (words_sent < ITEM_TARGET * (p + 1) / PHASES) send_chunk();
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("flc_word_delta_decoder_top verification clean");
    end else begin
      $display("flc_word_delta_decoder_top verification failed");
    end
    $finish;
  end

endmodule
